>>> sv/bpfa_pkg.sv
`default_nettype none

package bpfa_pkg;

  // Build-time sizes (WORD_BITS is a power of two)
  localparam int MAX_FRAMES = 4096;
  localparam int PAGE_BITS  = 12;
  localparam int WORD_BITS  = 64;

  localparam int ADDR_W    = 48;
  localparam int FC_W      = 13;
  localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIDX_W    = $clog2(WORD_BITS);
  localparam int FRAME_W   = WIDX_W + BIDX_W;
  localparam int NW_W      = $clog2(NUM_WORDS + 1);
  localparam int PFN_W     = ADDR_W - PAGE_BITS;

  // Operation codes on the mode field
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_FRAME_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_OOM       = 2'd1,
    STAT_FREED     = 2'd2,
    STAT_INVALID   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic write;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ok;
  } sts_t;

  // Lowest set bit among the word summary bits
  function automatic logic [WIDX_W-1:0] pe_words(input logic [NUM_WORDS-1:0] v);
    logic [WIDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (v[i]) idx = WIDX_W'(i);
    end
    return idx;
  endfunction

  // Lowest set bit within one map word
  function automatic logic [BIDX_W-1:0] pe_bits(input logic [WORD_BITS-1:0] v);
    logic [BIDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> sv/bpfa_ctrl.sv
`default_nettype none

module bpfa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire bpfa_pkg::sts_t sts,
  output bpfa_pkg::cmd_t      cmd,
  output logic                busy
);

  bpfa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bpfa_pkg::ST_IDLE: begin
        if (start) state_next = bpfa_pkg::ST_READ;
      end
      bpfa_pkg::ST_READ:   state_next = bpfa_pkg::ST_UPDATE;
      bpfa_pkg::ST_UPDATE: state_next = bpfa_pkg::ST_IDLE;
      default:             state_next = bpfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      bpfa_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      bpfa_pkg::ST_READ: begin
        cmd.read = 1'b1;
      end
      bpfa_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        cmd.write  = sts.ok;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/bpfa_datapath.sv
`default_nettype none

module bpfa_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bpfa_pkg::cmd_t               cmd,
  output bpfa_pkg::sts_t                    sts,
  input  wire logic                         mode,
  input  wire logic [bpfa_pkg::ADDR_W-1:0]  address,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [bpfa_pkg::ADDR_W-1:0]  cfg_data,
  output logic                              done,
  output logic [bpfa_pkg::ADDR_W-1:0]       frame_address,
  output logic [1:0]                        status
);

  // Config registers
  logic [bpfa_pkg::ADDR_W-1:0] base_address;
  logic [bpfa_pkg::FC_W-1:0]   frame_count;

  // Bitmap storage, per-word valid bits and full summary
  logic [bpfa_pkg::WORD_BITS-1:0] mem [bpfa_pkg::NUM_WORDS];
  logic [bpfa_pkg::NUM_WORDS-1:0] word_valid;
  logic [bpfa_pkg::NUM_WORDS-1:0] full;

  // Per-item registers
  logic                           op;
  logic [bpfa_pkg::WIDX_W-1:0]    widx;
  logic [bpfa_pkg::BIDX_W-1:0]    fbit;
  logic                           ok;
  logic [bpfa_pkg::WORD_BITS-1:0] rd_word;
  logic                           rd_valid;
  bpfa_pkg::status_t              status_q;

  logic [bpfa_pkg::FC_W-1:0]      n_act;
  logic [bpfa_pkg::FC_W:0]        nw_sum;
  logic [bpfa_pkg::NW_W-1:0]      nwords;
  logic [bpfa_pkg::NUM_WORDS-1:0] elig;
  logic [bpfa_pkg::ADDR_W-1:0]    aligned_base;
  logic [bpfa_pkg::ADDR_W-1:0]    offset;
  logic [bpfa_pkg::PFN_W-1:0]     free_frame;
  logic                           free_ok;

  logic [bpfa_pkg::WORD_BITS-1:0] cur;
  logic [bpfa_pkg::FC_W-1:0]      rem;
  logic [bpfa_pkg::WORD_BITS-1:0] vmask;
  logic [bpfa_pkg::WORD_BITS-1:0] avail;
  logic [bpfa_pkg::BIDX_W-1:0]    abit;
  logic                           a_ok;
  logic [bpfa_pkg::WORD_BITS-1:0] new_word;
  logic [bpfa_pkg::FRAME_W-1:0]   a_frame;
  logic [bpfa_pkg::ADDR_W-1:0]    a_addr;

  // Config port
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      frame_count  <= bpfa_pkg::FC_W'(bpfa_pkg::MAX_FRAMES);
    end else if (cfg_we) begin
      case (cfg_index)
        bpfa_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data;
        bpfa_pkg::CFG_FRAME_COUNT:  frame_count  <= cfg_data[bpfa_pkg::FC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp count, count of words touched by it
  always_comb begin
    n_act  = (frame_count > bpfa_pkg::FC_W'(bpfa_pkg::MAX_FRAMES)) ?
             bpfa_pkg::FC_W'(bpfa_pkg::MAX_FRAMES) : frame_count;
    nw_sum = {1'b0, n_act} + (bpfa_pkg::FC_W+1)'(bpfa_pkg::WORD_BITS - 1);
    nwords = bpfa_pkg::NW_W'(nw_sum >> bpfa_pkg::BIDX_W);
    for (int w = 0; w < bpfa_pkg::NUM_WORDS; w++) begin
      elig[w] = !full[w] && (bpfa_pkg::NW_W'(w) < nwords);
    end
  end

  // Free address decode
  always_comb begin
    aligned_base = {base_address[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_BITS],
                    {bpfa_pkg::PAGE_BITS{1'b0}}};
    offset       = address - aligned_base;
    free_frame   = offset[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_BITS];
    free_ok      = (offset[bpfa_pkg::PAGE_BITS-1:0] == '0) &&
                   (free_frame < bpfa_pkg::PFN_W'(n_act));
  end

  // Capture and read stages
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= mode;
      if (mode == bpfa_pkg::MODE_ALLOC) begin
        widx <= bpfa_pkg::pe_words(elig);
        fbit <= '0;
        ok   <= |elig;
      end else begin
        widx <= free_frame[bpfa_pkg::FRAME_W-1:bpfa_pkg::BIDX_W];
        fbit <= free_frame[bpfa_pkg::BIDX_W-1:0];
        ok   <= free_ok;
      end
    end
    if (cmd.read) begin
      rd_word  <= mem[widx];
      rd_valid <= word_valid[widx];
    end
  end

  // Update stage
  always_comb begin
    cur   = rd_valid ? rd_word : '0;
    rem   = n_act - bpfa_pkg::FC_W'({widx, {bpfa_pkg::BIDX_W{1'b0}}});
    vmask = (rem >= bpfa_pkg::FC_W'(bpfa_pkg::WORD_BITS)) ? '1 :
            ~({bpfa_pkg::WORD_BITS{1'b1}} << rem[bpfa_pkg::BIDX_W-1:0]);
    avail = ~cur & vmask;
    abit  = bpfa_pkg::pe_bits(avail);
    a_ok  = ok && (|avail);
    if (op == bpfa_pkg::MODE_ALLOC) begin
      new_word = cur | (bpfa_pkg::WORD_BITS'(1) << abit);
      sts.ok   = a_ok;
    end else begin
      new_word = cur & ~(bpfa_pkg::WORD_BITS'(1) << fbit);
      sts.ok   = ok;
    end
    a_frame = {widx, abit};
    a_addr  = aligned_base + (bpfa_pkg::ADDR_W'(a_frame) << bpfa_pkg::PAGE_BITS);
  end

  always_ff @(posedge clk) begin
    if (cmd.write) mem[widx] <= new_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      full       <= '0;
    end else if (cmd.write) begin
      word_valid[widx] <= 1'b1;
      full[widx]       <= &new_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (op == bpfa_pkg::MODE_ALLOC) begin
        status_q      <= a_ok ? bpfa_pkg::STAT_ALLOCATED : bpfa_pkg::STAT_OOM;
        frame_address <= a_ok ? a_addr : '0;
      end else begin
        status_q      <= ok ? bpfa_pkg::STAT_FREED : bpfa_pkg::STAT_INVALID;
        frame_address <= '0;
      end
    end
  end

  assign status = status_q;

  a_alloc_aligned: assert property (@(posedge clk) disable iff (rst)
    done && (status_q == bpfa_pkg::STAT_ALLOCATED) |->
      frame_address[bpfa_pkg::PAGE_BITS-1:0] == '0)
    else $error("allocated address not page aligned");

  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    done && (status_q != bpfa_pkg::STAT_ALLOCATED) |-> frame_address == '0)
    else $error("nonzero address on non-allocate result");

  a_write_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> word_valid[$past(widx)])
    else $error("written word not marked valid");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

>>> sv/bitmap_page_frame_allocator.sv
`default_nettype none

// Channel   Handshake              Fields
// -------   ---------------------  -----------------------------------------
// request   start && !busy         mode, address
// result    done (one-cycle pulse) frame_address, status
// config    cfg_we                 cfg_index, cfg_data
//
// Each request runs through capture (first-fit word chosen from the
// per-word full summary, or free address decoded), bitmap memory read,
// then bit encode and write-back; the result strobes on the next cycle,
// which may overlap with the next request's capture cycle.
// The single-port bitmap read/modify/write holds busy until write-back.
// Synchronous reset clears the per-word valid and full bits at once, so
// the bitmap reads as all free right away; no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per result.

module bitmap_page_frame_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        mode,
  input  wire logic [bpfa_pkg::ADDR_W-1:0] address,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bpfa_pkg::ADDR_W-1:0] cfg_data,
  output logic                             done,
  output logic [bpfa_pkg::ADDR_W-1:0]      frame_address,
  output logic [1:0]                       status
);

  bpfa_pkg::cmd_t cmd;
  bpfa_pkg::sts_t sts;

  // Sequencer: idle -> read -> update
  bpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Bitmap memory, summary bits, address math and result register
  bpfa_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .address       (address),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .frame_address (frame_address),
    .status        (status)
  );

endmodule

`default_nettype wire

>>> sim/bitmap_page_frame_allocator_test.sv
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_test;

  // Cycles with no request or result transfer before the run is abandoned
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [bpfa_pkg::ADDR_W-1:0] frame_address;
    bpfa_pkg::status_t           status;
  } frame_result_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic                        mode;
  logic [bpfa_pkg::ADDR_W-1:0] address;
  logic                        cfg_we;
  logic                        cfg_index;
  logic [bpfa_pkg::ADDR_W-1:0] cfg_data;
  logic                        done;
  logic [bpfa_pkg::ADDR_W-1:0] frame_address;
  logic [1:0]                  status;

  // Shadow of the allocator: one used bit per frame plus both registers
  bit                          frame_used [bpfa_pkg::MAX_FRAMES];
  logic [bpfa_pkg::ADDR_W-1:0] base_reg;
  logic [bpfa_pkg::FC_W-1:0]   frame_limit;

  frame_result_t     pending_results [$];

  int error_count;
  int stall_cycles;
  int requests_sent;
  int settings_used;
  int allocated_seen;
  int oom_seen;
  int freed_seen;
  int invalid_seen;

  bitmap_page_frame_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .address       (address),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .frame_address (frame_address),
    .status        (status)
  );

  always #2 clk = ~clk;

  function automatic logic [bpfa_pkg::ADDR_W-1:0] rand48();
    return bpfa_pkg::ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Frame count above the built capacity behaves as the capacity
  function automatic int active_frames();
    return (int'(frame_limit) > bpfa_pkg::MAX_FRAMES) ? bpfa_pkg::MAX_FRAMES :
           int'(frame_limit);
  endfunction

  // Base with its page offset dropped
  function automatic logic [bpfa_pkg::ADDR_W-1:0] page_origin();
    return {base_reg[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_BITS], {bpfa_pkg::PAGE_BITS{1'b0}}};
  endfunction

  function automatic logic [bpfa_pkg::ADDR_W-1:0] frame_to_address(input int frame);
    return page_origin() + (bpfa_pkg::ADDR_W'(frame) << bpfa_pkg::PAGE_BITS);
  endfunction

  // First-fit allocate or free against the shadow map
  function automatic void predict_request(input logic op,
                                          input logic [bpfa_pkg::ADDR_W-1:0] addr,
                                          output frame_result_t r);
    int                          limit;
    logic [bpfa_pkg::ADDR_W-1:0] offset;
    limit = active_frames();
    r.frame_address = '0;
    if (op == bpfa_pkg::MODE_ALLOC) begin
      r.status = bpfa_pkg::STAT_OOM;
      for (int f = 0; f < limit; f++) begin
        if (!frame_used[f]) begin
          frame_used[f]   = 1'b1;
          r.frame_address = frame_to_address(f);
          r.status        = bpfa_pkg::STAT_ALLOCATED;
          break;
        end
      end
    end else begin
      // wraps mod 2^48, so an address below the base lands far out of range
      offset = addr - page_origin();
      if (offset[bpfa_pkg::PAGE_BITS-1:0] != '0 ||
          offset[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_BITS] >= limit) begin
        r.status = bpfa_pkg::STAT_INVALID;
      end else begin
        frame_used[offset[bpfa_pkg::PAGE_BITS +: bpfa_pkg::FRAME_W]] = 1'b0;
        r.status = bpfa_pkg::STAT_FREED;
      end
    end
  endfunction

  // One request transfer; start stays high until the next negedge decides
  task automatic send_request(input logic op, input logic [bpfa_pkg::ADDR_W-1:0] addr);
    frame_result_t want;
    @(negedge clk);
    start   <= 1'b1;
    mode    <= op;
    address <= addr;
    do @(posedge clk); while (busy);
    predict_request(op, addr, want);
    pending_results.push_back(want);
    requests_sent++;
  endtask

  task automatic idle_gaps(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Wait for every result, then let the pipeline settle before any write
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic index, input logic [bpfa_pkg::ADDR_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    if (index == bpfa_pkg::CFG_BASE_ADDRESS) base_reg = data;
    else frame_limit = data[bpfa_pkg::FC_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [bpfa_pkg::ADDR_W-1:0] base,
                           input logic [bpfa_pkg::ADDR_W-1:0] count);
    drain();
    write_register(bpfa_pkg::CFG_BASE_ADDRESS, base);
    write_register(bpfa_pkg::CFG_FRAME_COUNT, count);
    settings_used++;
  endtask

  // Reset values: base 0, full 4096 frames
  task automatic test_reset_defaults();
    send_request(bpfa_pkg::MODE_ALLOC, '0);
    send_request(bpfa_pkg::MODE_ALLOC, '1);
    send_request(bpfa_pkg::MODE_FREE, 48'h0000_0000_1000);
    send_request(bpfa_pkg::MODE_ALLOC, '0);
    send_request(bpfa_pkg::MODE_FREE, 48'hFFFF_FFFF_F000);  // far past the last frame
    send_request(bpfa_pkg::MODE_FREE, 48'h0000_0000_0801);  // not on a page boundary
    send_request(bpfa_pkg::MODE_FREE, 48'h0000_0000_0000);
    send_request(bpfa_pkg::MODE_FREE, 48'h0000_0000_1000);
  endtask

  // Three frames whose addresses wrap through zero; unaligned base
  task automatic test_small_pool();
    configure(48'hFFFF_FFFF_E5A5, 48'h0000_0000_0003);
    repeat (4) send_request(bpfa_pkg::MODE_ALLOC, rand48());  // last one runs out
    send_request(bpfa_pkg::MODE_FREE, 48'hFFFF_FFFF_F000);
    send_request(bpfa_pkg::MODE_FREE, 48'hFFFF_FFFF_F000);    // double free
    send_request(bpfa_pkg::MODE_FREE, 48'hFFFF_FFFF_F800);    // misaligned
    send_request(bpfa_pkg::MODE_FREE, 48'h0000_0000_1000);    // frame 3, out of range
    send_request(bpfa_pkg::MODE_FREE, 48'hFFFF_FFFF_D000);    // below the base
    send_request(bpfa_pkg::MODE_ALLOC, '0);
    // shrink to one frame: frame 2 stays used but is no longer reachable
    configure(48'hFFFF_FFFF_E5A5, 48'h0000_0000_0001);
    send_request(bpfa_pkg::MODE_FREE, 48'h0000_0000_0000);
    send_request(bpfa_pkg::MODE_ALLOC, '0);
  endtask

  // Zero frames, then a count above capacity; upper data bits are dropped
  task automatic test_zero_and_oversize();
    configure(48'hFFFF_FFFF_E5A5, 48'hABCD_1234_E000);
    send_request(bpfa_pkg::MODE_ALLOC, '0);
    send_request(bpfa_pkg::MODE_FREE, 48'hFFFF_FFFF_E000);
    configure(48'hFFFF_FFFF_E000, 48'h0000_0000_1FFF);
    send_request(bpfa_pkg::MODE_ALLOC, '0);
    send_request(bpfa_pkg::MODE_FREE, 48'h0000_0000_0000);
    send_request(bpfa_pkg::MODE_ALLOC, '0);
  endtask

  function automatic logic [bpfa_pkg::ADDR_W-1:0] random_base();
    case ($urandom_range(3))
      0: return '0;
      1: return {32'hFFFF_FFFF, 16'($urandom())};  // near the top, frames wrap
      default: return rand48();
    endcase
  endfunction

  // Mostly small pools so allocation runs into the partial last word and OOM
  function automatic logic [bpfa_pkg::ADDR_W-1:0] random_count();
    logic [bpfa_pkg::FC_W-1:0] fc;
    case ($urandom_range(9))
      0: fc = '0;
      1: fc = bpfa_pkg::FC_W'($urandom_range(1, 3));
      2: fc = bpfa_pkg::FC_W'($urandom_range(63, 65));
      3: fc = bpfa_pkg::FC_W'($urandom_range(66, 130));
      4: fc = bpfa_pkg::FC_W'(bpfa_pkg::MAX_FRAMES);
      5: fc = bpfa_pkg::FC_W'($urandom_range(bpfa_pkg::MAX_FRAMES + 1, 8191));
      default: fc = bpfa_pkg::FC_W'($urandom_range(1, 200));
    endcase
    return {(bpfa_pkg::ADDR_W - bpfa_pkg::FC_W)'(rand48() >> bpfa_pkg::FC_W), fc};
  endfunction

  // Phases of random traffic, each under a fresh register setting
  task automatic test_random_traffic(input int idle_pct, input int item_budget);
    int                          sent_here;
    int                          phase_items;
    int                          alloc_pct;
    int                          limit;
    logic                        op;
    logic [bpfa_pkg::ADDR_W-1:0] addr;
    sent_here = 0;
    while (sent_here < item_budget) begin
      configure(random_base(), random_count());
      phase_items = $urandom_range(30, 90);
      if (phase_items > item_budget - sent_here) phase_items = item_budget - sent_here;
      alloc_pct   = $urandom_range(1) ? 85 : 50;
      limit       = active_frames();
      for (int i = 0; i < phase_items; i++) begin
        idle_gaps(idle_pct);
        op   = bpfa_pkg::MODE_FREE;
        addr = rand48();
        if ($urandom_range(99) < alloc_pct) begin
          op = bpfa_pkg::MODE_ALLOC;
        end else if ($urandom_range(99) < 80 && limit > 0) begin
          addr = frame_to_address($urandom_range(limit - 1));
        end else begin
          case ($urandom_range(2))
            0: ;  // raw random address
            1: addr = frame_to_address($urandom_range(limit)) +
                      bpfa_pkg::ADDR_W'($urandom_range(1, (1 << bpfa_pkg::PAGE_BITS) - 1));
            default: addr = frame_to_address(limit + $urandom_range(50));
          endcase
        end
        send_request(op, addr);
      end
      sent_here += phase_items;
    end
  endtask

  // Result checker: the receiver cannot stall, so every done is a transfer
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: frame_address %h status %0d",
               frame_address, status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (frame_address !== want.frame_address) begin
          $error("frame_address: expected %h, got %h", want.frame_address, frame_address);
          error_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        case (want.status)
          bpfa_pkg::STAT_ALLOCATED: allocated_seen++;
          bpfa_pkg::STAT_OOM:       oom_seen++;
          bpfa_pkg::STAT_FREED:     freed_seen++;
          default:                  invalid_seen++;
        endcase
      end
    end
  end

  // Watchdog: any transfer, either way, restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", stall_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    mode      = bpfa_pkg::MODE_ALLOC;
    address   = '0;
    cfg_we    = 1'b0;
    cfg_index = bpfa_pkg::CFG_BASE_ADDRESS;
    cfg_data  = '0;
    base_reg    = '0;
    frame_limit = bpfa_pkg::FC_W'(bpfa_pkg::MAX_FRAMES);
    for (int f = 0; f < bpfa_pkg::MAX_FRAMES; f++) frame_used[f] = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_small_pool();
    test_zero_and_oversize();
    // sender gaps: light, heavy, then none
    test_random_traffic(14, 420);
    test_random_traffic(78, 420);
    test_random_traffic(0, 410);

    drain();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("Ran %0d allocate/free requests across %0d register settings.",
             requests_sent, settings_used);
    $display("Results: %0d allocated, %0d out of memory, %0d freed, %0d invalid frees.",
             allocated_seen, oom_seen, freed_seen, invalid_seen);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> bitmap_page_frame_allocator.f
sv/bpfa_pkg.sv
sv/bpfa_ctrl.sv
sv/bpfa_datapath.sv
sv/bitmap_page_frame_allocator.sv
sim/bitmap_page_frame_allocator_test.sv
